### rtl/sd_data_block_receiver_unit_assert.svh
// Assertion macros shared by the receiver RTL.
`ifndef SD_DATA_BLOCK_RECEIVER_UNIT_ASSERT_SVH
`define SD_DATA_BLOCK_RECEIVER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check under reset disable
`define SDBR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds while reset is high
`define SDBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDBR_ASSERT(lbl, clk, rst, prop, msg)
`define SDBR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/sdbr_pkg.sv
`default_nettype none

package sdbr_pkg;

   localparam int unsigned BLOCK_BYTES_DEFAULT = 512;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
   localparam int unsigned COUNT_W             = 10;
   localparam int unsigned INDEX_W             = 9;
   localparam int unsigned CSR_INDEX_W         = 2;
   localparam int unsigned CSR_DATA_W          = 16;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [7:0]  START_TOKEN   = 8'hFE;

   // request codes
   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_DATA    = 3'd1;
   localparam logic [2:0] KIND_OK      = 3'd2;
   localparam logic [2:0] KIND_CRCERR  = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_EN     = 2'd1;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_TICK,
      OP_START,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       is_token;
      logic [7:0] data;
   } sdbr_item_type;

   // CRC16 CCITT, poly 0x1021, MSB first, one byte per call
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/sdbr_req_if.sv
`default_nettype none

interface sdbr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/sdbr_rsp_if.sv
`default_nettype none

interface sdbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_kind;
   logic [7:0] data_byte;
   logic [sdbr_pkg::INDEX_W-1:0] byte_index;
   logic       is_last;

   modport source (output valid, output out_kind, output data_byte, output byte_index,
                   output is_last, input ready);
   modport sink (input valid, input out_kind, input data_byte, input byte_index,
                 input is_last, output ready);
endinterface

`default_nettype wire

### rtl/sdbr_csr_if.sv
`default_nettype none

interface sdbr_csr_if;
   logic valid;
   logic ready;
   logic [sdbr_pkg::CSR_INDEX_W-1:0] index;
   logic [sdbr_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/sdbr_front.sv
`default_nettype none
`include "sd_data_block_receiver_unit_assert.svh"

module sdbr_front #(
   parameter int unsigned QUEUE_DEPTH = sdbr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   sdbr_req_if.sink               req_chan,
   output sdbr_pkg::sdbr_item_type item,
   output logic                   item_valid,
   input  logic                   item_pop
);
   import sdbr_pkg::*;

   localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
   localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

   sdbr_item_type     mem [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   sdbr_item_type     classified;
   logic              push;

   always_comb begin
      classified.data     = req_chan.rx_byte;
      classified.is_token = (req_chan.rx_byte == START_TOKEN);
      case (req_chan.req_type)
         REQ_BYTE:  classified.op = OP_BYTE;
         REQ_TICK:  classified.op = OP_TICK;
         REQ_START: classified.op = OP_START;
         default:   classified.op = OP_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != CountW'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign item           = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= classified;
      end
   end

   `SDBR_ASSERT(a_count_max, clock, reset, count_ff <= CountW'(QUEUE_DEPTH), "queue overfilled")
   `SDBR_ASSERT(a_pop_nonempty, clock, reset, item_pop |-> count_ff != '0, "pop from empty queue")
   `SDBR_ASSERT(a_push_grows, clock, reset, push && !item_pop |=> count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule

`default_nettype wire

### rtl/sdbr_back.sv
`default_nettype none
`include "sd_data_block_receiver_unit_assert.svh"

module sdbr_back #(
   parameter int unsigned BLOCK_BYTES = sdbr_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sdbr_pkg::sdbr_item_type item,
   input  logic                    item_valid,
   output logic                    item_pop,
   sdbr_csr_if.sink                csr_chan,
   sdbr_rsp_if.source              rsp_chan
);
   import sdbr_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_TOKEN  = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_CRC_HI = 3'd3;
   localparam logic [2:0] PH_CRC_LO = 3'd4;

   localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(BLOCK_BYTES - 1);

   logic [15:0]        timeout_ff;
   logic               crc_en_ff;
   logic [2:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         crc_hi_ff, crc_hi_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic [15:0]        elapsed_inc;
   logic               last;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;

   assign csr_chan.ready = 1'b1;
   assign item_pop       = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign last        = (count_ff == LAST_INDEX);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      crc_hi_in    = crc_hi_ff;
      elapsed_in   = elapsed_ff;
      rsp_kind_in  = KIND_NONE;
      rsp_data_in  = 8'd0;
      rsp_index_in = '0;
      rsp_last_in  = 1'b0;
      if (item.op == OP_START) begin
         phase_in   = PH_TOKEN;
         count_in   = '0;
         crc_in     = 16'd0;
         crc_hi_in  = 8'd0;
         elapsed_in = 16'd0;
      end else if (item.op == OP_NOP || phase_ff == PH_IDLE) begin
         // nothing to do
      end else if (item.op == OP_TICK) begin
         elapsed_in = elapsed_inc;
         if (elapsed_inc >= timeout_ff) begin
            phase_in    = PH_IDLE;
            rsp_kind_in = KIND_TIMEOUT;
         end
      end else if (elapsed_ff >= timeout_ff) begin
         // byte arriving after the deadline is dropped
         phase_in    = PH_IDLE;
         rsp_kind_in = KIND_TIMEOUT;
      end else begin
         case (phase_ff)
            PH_TOKEN: begin
               if (item.is_token) begin
                  phase_in = PH_DATA;
                  count_in = '0;
                  crc_in   = 16'd0;
               end
            end
            PH_DATA: begin
               crc_in       = crc16_byte(crc_ff, item.data);
               rsp_kind_in  = KIND_DATA;
               rsp_data_in  = item.data;
               rsp_index_in = count_ff[INDEX_W-1:0];
               rsp_last_in  = last;
               if (last) begin
                  phase_in = PH_CRC_HI;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_CRC_HI: begin
               crc_hi_in = item.data;
               phase_in  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               phase_in = PH_IDLE;
               if (crc_en_ff && ({crc_hi_ff, item.data} != crc_ff)) begin
                  rsp_kind_in = KIND_CRCERR;
               end else begin
                  rsp_kind_in = KIND_OK;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         crc_en_ff    <= 1'b1;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         crc_ff       <= 16'd0;
         crc_hi_ff    <= 8'd0;
         elapsed_ff   <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == CSR_TIMEOUT_MS) begin
               timeout_ff <= csr_chan.wdata[15:0];
            end else if (csr_chan.index == CSR_CRC_EN) begin
               crc_en_ff <= csr_chan.wdata[0];
            end
         end
         if (item_pop) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            crc_ff     <= crc_in;
            crc_hi_ff  <= crc_hi_in;
            elapsed_ff <= elapsed_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_index_ff <= rsp_index_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_kind   = rsp_kind_ff;
   assign rsp_chan.data_byte  = rsp_data_ff;
   assign rsp_chan.byte_index = rsp_index_ff;
   assign rsp_chan.is_last    = rsp_last_ff;

   `SDBR_ASSERT(a_count_range, clock, reset, count_ff <= LAST_INDEX, "byte count past block end")
   `SDBR_ASSERT(a_timeout_idle, clock, reset, item_pop && rsp_kind_in == KIND_TIMEOUT |=> phase_ff == PH_IDLE, "timeout left receiver armed")
   `SDBR_ASSERT(a_start_arms, clock, reset, item_pop && item.op == OP_START |=> phase_ff == PH_TOKEN && elapsed_ff == 16'd0, "start did not arm")
   `SDBR_ASSERT(a_last_only_data, clock, reset, rsp_valid_ff && rsp_kind_ff != KIND_DATA |-> !rsp_last_ff, "last flag on non-data result")

endmodule

`default_nettype wire

### rtl/sd_data_block_receiver_unit.sv
// SD card data block receiver, SPI mode, single block with CRC16 check.
// req_chan takes one item per cycle while ready: a received SPI byte, a 1 ms tick or a
// start request. Every accepted item gives exactly one item on rsp_chan:
// nothing, a payload byte with its index and last flag, block ok, CRC error
// or timeout. csr_chan writes timeout_ms (index 0) and crc_check_enable
// (index 1); it is always ready. The user must write it only while the
// receiver is idle; the block itself does not enforce this. An accepted
// item is written to the input queue, then loaded into the result register
// (valid from then) once that register is free. Throughput: one item per
// cycle while rsp_chan is ready; the back-end CRC takes a full byte per cycle.
// Reset (synchronous): queue empty, receiver idle, timeout 1000 ms, CRC
// check enabled, no result pending.
// When rsp_chan stalls, the result register holds and up to QUEUE_DEPTH
// further items are queued; req_chan.ready then drops until results drain.
`default_nettype none

module sd_data_block_receiver_unit #(
   parameter int unsigned BLOCK_BYTES = sdbr_pkg::BLOCK_BYTES_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = sdbr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   sdbr_req_if.sink    req_chan,
   sdbr_rsp_if.source  rsp_chan,
   sdbr_csr_if.sink    csr_chan
);
   import sdbr_pkg::*;

   sdbr_item_type item;
   logic          item_valid;
   logic          item_pop;

   sdbr_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   sdbr_back #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .csr_chan   (csr_chan),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

### bench/tb_sd_data_block_receiver_unit.sv
`timescale 1ns / 1ps

module tb_sd_data_block_receiver_unit;
   import sdbr_pkg::*;

   localparam int unsigned BLOCK_BYTES = BLOCK_BYTES_DEFAULT;
   localparam int unsigned MAX_REPORTS = 100;
   localparam logic [15:0] CRC_POLY    = 16'h1021;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         data;
      logic [INDEX_W-1:0] index;
      logic               last;
   } rx_output_type;

   // Mirror of the receiver: phase, counters, CRC and registers, plus the
   // outputs it owes for items already taken.
   class receiver_mirror;
      typedef enum logic [2:0] {ST_IDLE, ST_TOKEN, ST_DATA, ST_CRC_HI, ST_CRC_LO} rx_phase_type;

      int unsigned   block_bytes;
      rx_phase_type  phase;
      logic [9:0]    byte_count;
      logic [15:0]   crc_acc;
      logic [7:0]    crc_high;
      logic [15:0]   elapsed_ms;
      logic [15:0]   timeout_ms;
      bit            crc_check_on;
      rx_output_type outputs_due[$];
      int            mismatches;

      function new(int unsigned n_bytes);
         block_bytes  = n_bytes;
         phase        = ST_IDLE;
         byte_count   = '0;
         crc_acc      = '0;
         crc_high     = '0;
         elapsed_ms   = '0;
         timeout_ms   = TIMEOUT_RESET;
         crc_check_on = 1'b1;
         mismatches   = 0;
      endfunction

      static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            if (c[15] ^ b[i]) begin
               c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
               c = {c[14:0], 1'b0};
            end
         end
         return c;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_TIMEOUT_MS) begin
            timeout_ms = val;
         end else if (idx == CSR_CRC_EN) begin
            crc_check_on = val[0];
         end
      endfunction

      function rx_output_type next_output(op_type op, logic [7:0] b);
         rx_output_type r;
         bit            at_end;
         r = '0;
         r.kind = KIND_NONE;
         if (op == OP_START) begin
            phase      = ST_TOKEN;
            byte_count = '0;
            crc_acc    = '0;
            crc_high   = '0;
            elapsed_ms = '0;
            return r;
         end
         if (op == OP_NOP || phase == ST_IDLE) begin
            return r;
         end
         if (op == OP_TICK) begin
            if (elapsed_ms != 16'hFFFF) begin
               elapsed_ms++;
            end
            if (elapsed_ms >= timeout_ms) begin
               phase = ST_IDLE;
               r.kind = KIND_TIMEOUT;
            end
            return r;
         end
         // a byte arriving past the deadline is dropped
         if (elapsed_ms >= timeout_ms) begin
            phase = ST_IDLE;
            r.kind = KIND_TIMEOUT;
            return r;
         end
         case (phase)
            ST_TOKEN: begin
               if (b == START_TOKEN) begin
                  phase      = ST_DATA;
                  byte_count = '0;
                  crc_acc    = '0;
               end
            end
            ST_DATA: begin
               at_end  = (int'(byte_count) + 1 >= int'(block_bytes));
               crc_acc = crc_step(crc_acc, b);
               r.kind  = KIND_DATA;
               r.data  = b;
               r.index = byte_count[INDEX_W-1:0];
               r.last  = at_end;
               if (at_end) begin
                  phase = ST_CRC_HI;
               end else begin
                  byte_count++;
               end
            end
            ST_CRC_HI: begin
               crc_high = b;
               phase = ST_CRC_LO;
            end
            ST_CRC_LO: begin
               phase = ST_IDLE;
               if (crc_check_on && {crc_high, b} != crc_acc) begin
                  r.kind = KIND_CRCERR;
               end else begin
                  r.kind = KIND_OK;
               end
            end
            default: phase = ST_IDLE;
         endcase
         return r;
      endfunction

      function void take_item(op_type op, logic [7:0] b);
         outputs_due.push_back(next_output(op, b));
      endfunction

      function int pending();
         return outputs_due.size();
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            if (mismatches < MAX_REPORTS) begin
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
            mismatches++;
         end
      endfunction

      function void check_output(rx_output_type got);
         rx_output_type want;
         if (outputs_due.size() == 0) begin
            if (mismatches < MAX_REPORTS) begin
               $display("%0t: unexpected output, expected none, actual kind %0h data %0h",
                        $time, got.kind, got.data);
            end
            mismatches++;
            return;
         end
         want = outputs_due.pop_front();
         compare_field("out_kind", want.kind, got.kind);
         compare_field("data_byte", want.data, got.data);
         compare_field("byte_index", want.index, got.index);
         compare_field("is_last", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;

   sdbr_req_if req_chan();
   sdbr_rsp_if rsp_chan();
   sdbr_csr_if csr_chan();

   sd_data_block_receiver_unit #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   receiver_mirror mirror;
   bit calm;
   bit no_gaps;
   int hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("FAIL sd_data_block_receiver_unit");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rx_output_type seen;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen.kind  = rsp_chan.out_kind;
         seen.data  = rsp_chan.data_byte;
         seen.index = rsp_chan.byte_index;
         seen.last  = rsp_chan.is_last;
         mirror.check_output(seen);
      end
   end

   task automatic send_req(op_type op, logic [7:0] b);
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.rx_byte  <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      mirror.take_item(op, b);
      if (!calm && !no_gaps && $urandom_range(0, 6) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // wait until every owed output is out, then let the pipeline settle
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= val;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      mirror.write_register(idx, val);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_block(bit bad_crc, bit with_ticks);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = '0;
      send_req(OP_START, 8'($urandom));
      repeat ($urandom_range(0, 3)) begin
         do b = 8'($urandom); while (b == START_TOKEN);
         send_req($urandom_range(0, 3) == 0 ? OP_NOP : OP_BYTE, b);
      end
      send_req(OP_BYTE, START_TOKEN);
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         b = 8'($urandom);
         crc = receiver_mirror::crc_step(crc, b);
         send_req(OP_BYTE, b);
         if (with_ticks && $urandom_range(0, 199) == 0) begin
            send_req(OP_TICK, 8'($urandom));
         end
         if ($urandom_range(0, 299) == 0) begin
            send_req(OP_NOP, 8'($urandom));
         end
      end
      if (bad_crc) begin
         crc ^= 16'd1 << $urandom_range(0, 15);
      end
      send_req(OP_BYTE, crc[15:8]);
      send_req(OP_BYTE, crc[7:0]);
   endtask

   task automatic run_sequence();
      int pick;
      int count;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         // armed block cut short by a restart, a timeout or the end of input
         send_req(OP_START, 8'($urandom));
         if ($urandom_range(0, 3) != 0) begin
            send_req(OP_BYTE, START_TOKEN);
         end
         repeat ($urandom_range(0, 6)) send_req(OP_TICK, 8'($urandom));
         count = $urandom_range(0, 14);
         repeat (count) send_req(OP_BYTE, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 8)) send_req(op_type'($urandom_range(0, 3)), 8'($urandom));
      end
   endtask

   initial begin
      logic [15:0] tmo;
      bit          crc_en;
      int          drain;
      mirror = new(BLOCK_BYTES);
      calm = 1'b0;
      no_gaps = 1'b0;
      hold_off_cycles = 0;
      reset <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= OP_BYTE;
      req_chan.rx_byte  <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_TIMEOUT_MS;
      csr_chan.wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle receiver ignores everything
      send_req(OP_BYTE, 8'h00);
      send_req(OP_BYTE, 8'hFF);
      send_req(OP_TICK, 8'h5A);
      send_req(OP_NOP, 8'hA5);
      // armed: junk, tick and unused code before the token
      send_req(OP_START, 8'hFF);
      send_req(OP_BYTE, 8'h12);
      send_req(OP_TICK, 8'h00);
      send_req(OP_NOP, START_TOKEN);
      send_req(OP_BYTE, START_TOKEN);
      send_req(OP_BYTE, 8'hFF);
      send_req(OP_BYTE, 8'h00);
      // restart drops the block in progress
      send_req(OP_START, 8'h00);
      send_req(OP_BYTE, START_TOKEN);
      send_req(OP_BYTE, 8'h5A);
      // tick reaching the limit
      settle();
      write_csr(CSR_TIMEOUT_MS, 16'd3);
      repeat (3) send_req(OP_TICK, 8'($urandom));
      // limit lowered under an armed receiver, next byte times out
      send_req(OP_START, 8'h00);
      send_req(OP_TICK, 8'h00);
      send_req(OP_TICK, 8'hFF);
      settle();
      write_csr(CSR_TIMEOUT_MS, 16'd1);
      send_req(OP_BYTE, START_TOKEN);
      // zero limit: first byte or tick times out
      settle();
      write_csr(CSR_TIMEOUT_MS, 16'd0);
      send_req(OP_START, 8'h00);
      send_req(OP_BYTE, 8'h00);
      send_req(OP_START, 8'h00);
      send_req(OP_TICK, 8'h00);

      // largest limit keeps the block open through ticks
      settle();
      write_csr(CSR_TIMEOUT_MS, 16'hFFFF);
      send_req(OP_START, 8'($urandom));
      repeat (4) send_req(OP_TICK, 8'($urandom));
      send_req(OP_BYTE, START_TOKEN);
      send_req(OP_TICK, 8'($urandom));
      send_req(OP_BYTE, 8'($urandom));

      for (int round = 0; round < 7; round++) begin
         settle();
         calm = (round == 6);
         case (round)
            0: begin tmo = 16'd1000; crc_en = 1'b1; end
            1: begin tmo = 16'd4; crc_en = 1'b0; end
            2: begin tmo = 16'd0; crc_en = 1'b1; end
            3: begin tmo = 16'hFFFF; crc_en = 1'b0; end
            4: begin tmo = 16'($urandom_range(1, 20)); crc_en = 1'b1; end
            5: begin tmo = 16'd2; crc_en = 1'b1; end
            default: begin tmo = 16'($urandom); crc_en = 1'($urandom); end
         endcase
         write_csr(CSR_TIMEOUT_MS, tmo);
         write_csr(CSR_CRC_EN, {15'($urandom), crc_en});
         if (round == 0) begin
            // receiver holds off while items keep coming: input must back up
            hold_off_cycles = 200;
            no_gaps = 1'b1;
            send_block($urandom_range(0, 1) == 1, 1'b1);
            no_gaps = 1'b0;
         end
         repeat ((round == 6) ? 3 : 6) run_sequence();
      end

      req_chan.valid <= 1'b0;
      for (drain = 0; drain < 20000 && mirror.pending() != 0; drain++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.pending() == 0) begin
         $display("PASS sd_data_block_receiver_unit");
      end else begin
         if (mirror.pending() != 0) begin
            $display("%0t: %0d outputs never arrived", $time, mirror.pending());
         end
         $display("FAIL sd_data_block_receiver_unit");
      end
      $finish;
   end

endmodule
